// ----- hw/rtl/ncp_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ncp_pkg
// Shared widths, character codes, result kinds and the classified byte word
// for the coded netstring parser.
// ----------------------------------------------------------------------------
package ncp_pkg;

	// Declared length counter width.
	localparam int LEN_W = 24;
	// Width of the limit register.
	localparam int MAXLEN_W = 24;
	// Common compare width for length checks (covers LEN_W + 4 and MAXLEN_W).
	localparam int CMP_W = 36;
	localparam logic [CMP_W-1:0] LEN_CAP = (CMP_W'(1) << LEN_W) - CMP_W'(1);

	localparam int CODE_W = 31;
	localparam logic [CODE_W-1:0] CODE_MAX = {CODE_W{1'b1}};

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_SPACE = 8'h20;

	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// Queue between front and back.
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One input byte with its character class.
	typedef struct packed {
		logic [7:0] byte_val;
		logic       is_digit;
		logic [3:0] digit;
		logic       is_colon;
		logic       is_comma;
		logic       is_space;
	} cls_t;

	// Push side of the queue.
	typedef struct packed {
		logic push;
		cls_t word;
	} qpush_t;

	// Pop side of the queue.
	typedef struct packed {
		logic valid;
		cls_t word;
	} qhead_t;

endpackage
`default_nettype wire

// ----- hw/rtl/ncp_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ncp_front
// Accept stream bytes and classify them into digit / separator flags.
// ----------------------------------------------------------------------------
module ncp_front (
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [7:0]      s_tdata,   // [7:0] in_byte
	input  wire logic            q_full,
	output ncp_pkg::qpush_t      qpush
);

	logic is_digit;

	assign is_digit = (s_tdata >= ncp_pkg::CH_ZERO) && (s_tdata <= ncp_pkg::CH_NINE);
	assign s_tready = !q_full;

	always_comb begin
		qpush.push          = s_tvalid && !q_full;
		qpush.word.byte_val = s_tdata;
		qpush.word.is_digit = is_digit;
		qpush.word.digit    = 4'(s_tdata - ncp_pkg::CH_ZERO);
		qpush.word.is_colon = (s_tdata == ncp_pkg::CH_COLON);
		qpush.word.is_comma = (s_tdata == ncp_pkg::CH_COMMA);
		qpush.word.is_space = (s_tdata == ncp_pkg::CH_SPACE);
	end

endmodule
`default_nettype wire

// ----- hw/rtl/ncp_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ncp_queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
module ncp_queue (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire ncp_pkg::qpush_t  qpush,
	output logic                  full,
	input  wire logic             pop,
	output ncp_pkg::qhead_t       head
);

	ncp_pkg::cls_t                    mem_q [ncp_pkg::QDEPTH];
	logic [ncp_pkg::QPTR_W-1:0]       wr_q;
	logic [ncp_pkg::QPTR_W-1:0]       rd_q;
	logic [ncp_pkg::QCNT_W-1:0]       cnt_q;
	logic                             do_pop;

	assign full       = (cnt_q == ncp_pkg::QCNT_W'(ncp_pkg::QDEPTH));
	assign head.valid = (cnt_q != '0);
	assign head.word  = mem_q[rd_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (qpush.push) begin
			mem_q[wr_q] <= qpush.word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (qpush.push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			case ({qpush.push, do_pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ----- hw/rtl/ncp_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ncp_back
// Two-level netstring state machine and the output register.
// ----------------------------------------------------------------------------
module ncp_back (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire ncp_pkg::qhead_t               head,
	output logic                               pop,
	input  wire logic [ncp_pkg::MAXLEN_W-1:0]  max_len,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	output logic [39:0]                        m_tdata,
	output logic [2:0]                         m_tuser
);

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_LEN,
		PH_CODE,
		PH_OVER,
		PH_PAY,
		PH_TERM
	} phase_t;

	typedef enum logic [1:0] {
		EV_NONE,
		EV_DATA,
		EV_END,
		EV_ERR
	} ev_t;

	typedef struct packed {
		phase_t                       phase;
		logic [ncp_pkg::LEN_W-1:0]    rem;
		logic [ncp_pkg::CODE_W-1:0]   code;
	} lvl_t;

	typedef struct packed {
		lvl_t nxt;
		ev_t  ev;
	} step_t;

	localparam lvl_t LVL_CLR = '{phase: PH_IDLE, rem: '0, code: '0};

	function automatic step_t level_step(input lvl_t cur, input ncp_pkg::cls_t c,
	                                     input logic [ncp_pkg::MAXLEN_W-1:0] lim);
		logic [ncp_pkg::LEN_W+3:0]    rem_w;
		logic [ncp_pkg::LEN_W+3:0]    vlen;
		logic [ncp_pkg::CODE_W+3:0]   code_w;
		logic [ncp_pkg::CODE_W+3:0]   vcode;
		logic [ncp_pkg::LEN_W-1:0]    rem_dec;
		logic                         len_bad;
		step_t                        r;
		rem_w   = {4'b0, cur.rem};
		vlen    = (rem_w << 3) + (rem_w << 1) + (ncp_pkg::LEN_W+4)'(c.digit);
		code_w  = {4'b0, cur.code};
		vcode   = (code_w << 3) + (code_w << 1) + (ncp_pkg::CODE_W+4)'(c.digit);
		rem_dec = cur.rem - 1'b1;
		len_bad = (ncp_pkg::CMP_W'(vlen) > ncp_pkg::CMP_W'(lim))
		       || (ncp_pkg::CMP_W'(vlen) > ncp_pkg::LEN_CAP);
		r.nxt = LVL_CLR;
		r.ev  = EV_ERR;
		unique case (cur.phase)
			PH_IDLE, PH_LEN: begin
				if (c.is_digit) begin
					if (!len_bad) begin
						r.nxt.phase = PH_LEN;
						r.nxt.rem   = vlen[ncp_pkg::LEN_W-1:0];
						r.nxt.code  = cur.code;
						r.ev        = EV_NONE;
					end
				end else if (c.is_colon) begin
					r.nxt.phase = PH_CODE;
					r.nxt.rem   = cur.rem;
					r.nxt.code  = '0;
					r.ev        = EV_NONE;
				end
			end
			PH_CODE, PH_OVER: begin
				if (c.is_digit) begin
					if (vcode <= (ncp_pkg::CODE_W+4)'(ncp_pkg::CODE_MAX)) begin
						r.nxt.code  = vcode[ncp_pkg::CODE_W-1:0];
						r.nxt.phase = cur.phase;
						r.nxt.rem   = cur.rem;
						if (cur.phase == PH_CODE) begin
							if (cur.rem == '0) begin
								r.nxt.phase = PH_OVER;
							end else begin
								r.nxt.rem = rem_dec;
							end
						end
						r.ev = EV_NONE;
					end
				end else if (c.is_comma) begin
					r.ev = EV_END;
				end else if (c.is_space && cur.phase == PH_CODE && cur.rem != '0) begin
					r.nxt.rem   = rem_dec;
					r.nxt.code  = cur.code;
					r.nxt.phase = (rem_dec != '0) ? PH_PAY : PH_TERM;
					r.ev        = EV_NONE;
				end
			end
			PH_PAY: begin
				r.nxt.rem   = rem_dec;
				r.nxt.code  = cur.code;
				r.nxt.phase = (rem_dec == '0) ? PH_TERM : PH_PAY;
				r.ev        = EV_DATA;
			end
			PH_TERM: begin
				if (c.is_comma) begin
					r.ev = EV_END;
				end
			end
			default: begin
				r.ev = EV_ERR;
			end
		endcase
		return r;
	endfunction

	lvl_t  outer_q, inner_q;
	logic  seen_q, discard_q;

	lvl_t  outer_d, inner_d;
	logic  seen_d, discard_d;
	ev_t   ev;
	logic  nest;
	logic [ncp_pkg::CODE_W-1:0] done_code;
	step_t so, si;
	logic  outer_cont;
	logic [ncp_pkg::LEN_W-1:0] orem_dec;
	logic  term_ok;

	logic                          valid_q;
	logic [1:0]                    kind_q;
	logic [7:0]                    data_q;
	logic [ncp_pkg::CODE_W-1:0]    code_q;
	logic                          inner_flag_q;

	assign pop        = head.valid && (!valid_q || m_tready);
	assign outer_cont = (outer_q.code == '0);
	assign orem_dec   = outer_q.rem - 1'b1;
	assign so         = level_step(outer_q, head.word, max_len);
	assign si         = level_step(inner_q, head.word, max_len);
	assign term_ok    = head.word.is_comma && (inner_q.phase == PH_IDLE) && seen_q;

	always_comb begin
		outer_d   = outer_q;
		inner_d   = inner_q;
		seen_d    = seen_q;
		discard_d = discard_q;
		ev        = EV_NONE;
		nest      = 1'b0;
		done_code = '0;
		if (outer_q.phase == PH_PAY && outer_cont) begin
			// Container payload: count it down and feed the inner level.
			outer_d.rem   = orem_dec;
			outer_d.phase = (orem_dec == '0) ? PH_TERM : PH_PAY;
			if (!discard_q) begin
				inner_d   = si.nxt;
				ev        = si.ev;
				nest      = 1'b1;
				done_code = inner_q.code;
				if (si.ev == EV_END) begin
					seen_d = 1'b1;
				end
				if (si.ev == EV_ERR) begin
					discard_d = 1'b1;
				end
			end
		end else if (outer_q.phase == PH_TERM && outer_cont) begin
			// Container terminator: silent if valid or after an inner error.
			outer_d   = LVL_CLR;
			inner_d   = LVL_CLR;
			seen_d    = 1'b0;
			discard_d = 1'b0;
			ev        = (discard_q || term_ok) ? EV_NONE : EV_ERR;
		end else begin
			outer_d   = so.nxt;
			ev        = so.ev;
			done_code = outer_q.code;
			if (so.ev == EV_ERR) begin
				inner_d   = LVL_CLR;
				seen_d    = 1'b0;
				discard_d = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q   <= LVL_CLR;
			inner_q   <= LVL_CLR;
			seen_q    <= 1'b0;
			discard_q <= 1'b0;
			valid_q   <= 1'b0;
		end else begin
			if (pop) begin
				outer_q   <= outer_d;
				inner_q   <= inner_d;
				seen_q    <= seen_d;
				discard_q <= discard_d;
				valid_q   <= (ev != EV_NONE);
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			inner_flag_q <= nest;
			data_q       <= (ev == EV_DATA) ? head.word.byte_val : 8'd0;
			code_q       <= (ev == EV_END) ? done_code : '0;
			unique case (ev)
				EV_DATA: begin
					kind_q <= ncp_pkg::KIND_DATA;
				end
				EV_END: begin
					kind_q <= ncp_pkg::KIND_END;
				end
				default: begin
					kind_q <= ncp_pkg::KIND_ERR;
				end
			endcase
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {1'b0, code_q, data_q};
	assign m_tuser  = {inner_flag_q, kind_q};

endmodule
`default_nettype wire

// ----- hw/rtl/coded_netstring_parser.sv -----
`default_nettype none
// An accepted byte is held in the queue, and its result in the output register.
// Throughput: one byte per cycle unless the output stalls, set by the single-byte
// step of the back-end parser; the 4-word queue absorbs output stalls until full.
// Reset (arst_n low) clears both parsing levels, the queue and the output,
// and sets max_length to 16777215.
// ----------------------------------------------------------------------------
// coded_netstring_parser
// Streaming parser for coded netstrings "len:code payload," with one level
// of containers (code 0). Emits payload bytes, message ends and errors.
// ----------------------------------------------------------------------------
module coded_netstring_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// Input byte stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,    // [7:0] in_byte
	// Result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,    // [7:0] data, [38:8] code, [39] zero pad
	output logic [2:0]       m_tuser,    // [1:0] kind, [2] inner
	// Limit register write channel
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [23:0] cfg_data    // [23:0] max_length
);

	ncp_pkg::qpush_t                    qpush;
	ncp_pkg::qhead_t                    head;
	logic                               q_full;
	logic                               pop;
	logic [ncp_pkg::MAXLEN_W-1:0]       max_len_q;

	// The limit register takes a word whenever offered; the user must write it only
	// while the parser is idle, as the block itself does not enforce this.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= '1;
		end else if (cfg_valid) begin
			max_len_q <= cfg_data;
		end
	end

	// Front: accept and classify each word.
	ncp_front u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.qpush    (qpush)
	);

	// Hold classified words so the front waits on output stalls only once the queue is full.
	ncp_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.qpush  (qpush),
		.full   (q_full),
		.pop    (pop),
		.head   (head)
	);

	// Back: advance the outer and inner levels, register at most one result per word.
	ncp_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.max_len  (max_len_q),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
`default_nettype wire
